FILE: src/sts_pkg.sv
// Shared constants, codes and controller/datapath types for the sorted key table.
package sts_pkg;

  localparam int STS_TABLE_DEPTH = 32;

  localparam int KEY_W = 32;  // key width
  localparam int IDX_W = 5;   // entry_index width
  localparam int CNT_W = 6;   // entry_count width, also config data width
  localparam int POS_W = 5;   // position width
  localparam int PRB_W = 6;   // probe_count width
  localparam int ACT_W = 2;   // action width

  typedef enum logic [ACT_W-1:0] {
    ACT_WRITE  = 2'd0,
    ACT_SORT   = 2'd1,
    ACT_SEARCH = 2'd2
  } action_t;

  typedef enum logic {
    REG_ENTRY_COUNT   = 1'b0,
    REG_SEARCH_METHOD = 1'b1
  } reg_index_t;

  typedef enum logic {
    KIND_SORT_DONE = 1'b0,
    KIND_SEARCH    = 1'b1
  } result_kind_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LIN,
    ST_BIN_RD,
    ST_BIN_CMP,
    ST_SRT_RD,
    ST_SRT_SCAN,
    ST_SWAP_A,
    ST_SWAP_B,
    ST_EMIT
  } state_t;

  typedef enum logic [3:0] {
    OP_IDLE,
    OP_ACCEPT,
    OP_LIN,
    OP_BIN_RD,
    OP_BIN_CMP,
    OP_SRT_RD,
    OP_SRT_SCAN,
    OP_SWAP_A,
    OP_SWAP_B
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
    logic   load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic cnt_zero;
    logic cnt_le1;
    logic method_bin;
    logic lin_hit;
    logic scan_last;
    logic bin_empty;
    logic bin_hit;
    logic srt_more;
  } dp_status_t;

endpackage

FILE: src/sts_if.sv
// Channel interfaces: input items, result items and configuration writes.
interface sts_in_if;
  import sts_pkg::*;
  logic                    valid;
  logic                    ready;
  logic [ACT_W-1:0]        action;
  logic [IDX_W-1:0]        entry_index;
  logic signed [KEY_W-1:0] entry_value;
  logic signed [KEY_W-1:0] search_key;

  modport source (output valid, action, entry_index, entry_value, search_key, input ready);
  modport sink (input valid, action, entry_index, entry_value, search_key, output ready);
endinterface

interface sts_out_if;
  import sts_pkg::*;
  logic             valid;
  logic             ready;
  logic             result_kind;
  logic             found;
  logic [POS_W-1:0] position;
  logic [PRB_W-1:0] probe_count;

  modport source (output valid, result_kind, found, position, probe_count, input ready);
  modport sink (input valid, result_kind, found, position, probe_count, output ready);
endinterface

interface sts_cfg_if;
  import sts_pkg::*;
  logic             valid;
  logic             ready;
  logic             reg_index;
  logic [CNT_W-1:0] wdata;

  modport source (output valid, reg_index, wdata, input ready);
  modport sink (input valid, reg_index, wdata, output ready);
endinterface

FILE: src/sorted_table_key_search.sv
// Top level of the sorted key table: write, sort and search of signed 32-bit keys.
//
// Usage:
//   in_ch carries one item per valid/ready handshake: action selects write entry,
//   sort table or search key. A write stores entry_value at entry_index and gives
//   no result; an index at or beyond the table depth is dropped. Action code 3 is
//   dropped as well. A sort gives one done result, a search one answer with found,
//   position and probe_count on out_ch. cfg_ch writes entry_count (index 0) and
//   search_method (index 1); it is always ready. The user must write it only
//   while idle; the block itself does not enforce this.
// Linear search makes one probe per cycle over the memory's single read port
// with a registered read. Binary search reads and compares one probe at a time,
// since each address follows from the previous key read. Sort: each pass from
// start s scans entries s to n - 1 (n = entry_count clamped to the depth) for
// the minimum and swaps it into place. The result is then registered for out_ch.
// Reset clears the controller and both config registers; the key memory is not
// cleared and an entry must be written before a sort or search reads it.
// When the receiver stalls, the result waits in the output register and the next
// item is still accepted; its result waits in the datapath until the slot frees.
module sorted_table_key_search #(
  parameter int TABLE_DEPTH = sts_pkg::STS_TABLE_DEPTH
) (
  input logic        clk,
  input logic        rst_n,
  sts_in_if.sink     in_ch,
  sts_out_if.source  out_ch,
  sts_cfg_if.sink    cfg_ch
);
  import sts_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  // Config writes are registered directly, so the port never stalls.
  assign cfg_ch.ready = 1'b1;

  sts_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_action (in_ch.action),
    .out_ready (out_ch.ready),
    .status    (status),
    .cmd       (cmd),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid)
  );

  sts_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_ch.valid),
    .cfg_idx         (cfg_ch.reg_index),
    .cfg_wdata       (cfg_ch.wdata),
    .in_action       (in_ch.action),
    .in_entry_index  (in_ch.entry_index),
    .in_entry_value  (in_ch.entry_value),
    .in_search_key   (in_ch.search_key),
    .cmd             (cmd),
    .status          (status),
    .out_result_kind (out_ch.result_kind),
    .out_found       (out_ch.found),
    .out_position    (out_ch.position),
    .out_probe_count (out_ch.probe_count)
  );

endmodule

FILE: src/sts_datapath.sv
// Datapath: key memory, config registers, scan/search/sort registers and result register.
module sts_datapath #(
  parameter int TABLE_DEPTH = sts_pkg::STS_TABLE_DEPTH
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic                             cfg_idx,
  input  logic [sts_pkg::CNT_W-1:0]        cfg_wdata,
  input  logic [sts_pkg::ACT_W-1:0]        in_action,
  input  logic [sts_pkg::IDX_W-1:0]        in_entry_index,
  input  logic signed [sts_pkg::KEY_W-1:0] in_entry_value,
  input  logic signed [sts_pkg::KEY_W-1:0] in_search_key,
  input  sts_pkg::dp_cmd_t                 cmd,
  output sts_pkg::dp_status_t              status,
  output logic                             out_result_kind,
  output logic                             out_found,
  output logic [sts_pkg::POS_W-1:0]        out_position,
  output logic [sts_pkg::PRB_W-1:0]        out_probe_count
);
  import sts_pkg::*;

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  logic [KEY_W-1:0] mem [TABLE_DEPTH];

  logic signed [KEY_W-1:0] rd_data_r, key_r, min_r, first_r;
  logic [CW-1:0]           n_r, i_r, lo_r, hi1_r, s_r, cmp_idx_r, mid_r, best_r;
  logic                    cmp_vld_r, head_r;
  logic [CNT_W-1:0]        entry_count_r;
  logic                    search_method_r;
  logic                    res_kind_r, res_found_r;
  logic [POS_W-1:0]        res_pos_r;
  logic [PRB_W-1:0]        res_probes_r;
  logic                    out_kind_r, out_found_r;
  logic [POS_W-1:0]        out_pos_r;
  logic [PRB_W-1:0]        out_probes_r;

  logic [CW-1:0]    used_cnt, n_last, mid;
  logic [CW:0]      mid_sum;
  logic             issue, key_eq, rd_gt_key, rd_lt_min;
  logic [AW-1:0]    rd_addr, wr_addr;
  logic             wr_en;
  logic [KEY_W-1:0] wr_data;

  // Clamp the configured count to the table depth.
  always_comb begin
    if (32'(entry_count_r) > 32'(TABLE_DEPTH)) begin
      used_cnt = CW'(TABLE_DEPTH);
    end else begin
      used_cnt = CW'(entry_count_r);
    end
  end

  assign n_last    = n_r - CW'(1);
  assign mid_sum   = {1'b0, lo_r} + {1'b0, hi1_r} - (CW+1)'(1);
  assign mid       = mid_sum[CW:1];
  assign issue     = i_r < n_r;
  assign key_eq    = rd_data_r == key_r;
  assign rd_gt_key = rd_data_r > key_r;
  assign rd_lt_min = rd_data_r < min_r;

  always_comb begin
    case (cmd.op)
      OP_BIN_RD: rd_addr = mid[AW-1:0];
      OP_SRT_RD: rd_addr = s_r[AW-1:0];
      default:   rd_addr = i_r[AW-1:0];
    endcase
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = AW'(in_entry_index);
    wr_data = in_entry_value;
    case (cmd.op)
      OP_ACCEPT: begin
        wr_en = (in_action == ACT_WRITE) && (32'(in_entry_index) < 32'(TABLE_DEPTH));
      end
      OP_SWAP_A: begin
        wr_en   = 1'b1;
        wr_addr = s_r[AW-1:0];
        wr_data = min_r;
      end
      OP_SWAP_B: begin
        wr_en   = 1'b1;
        wr_addr = best_r[AW-1:0];
        wr_data = first_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_count_r   <= '0;
      search_method_r <= 1'b0;
    end else if (cfg_we) begin
      if (cfg_idx == REG_ENTRY_COUNT) begin
        entry_count_r <= cfg_wdata;
      end else begin
        search_method_r <= cfg_wdata[0];
      end
    end
  end

  // Compare-stage valid and the head flag of a sort pass.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmp_vld_r <= 1'b0;
      head_r    <= 1'b0;
    end else begin
      case (cmd.op) inside
        OP_ACCEPT:           cmp_vld_r <= 1'b0;
        OP_LIN, OP_SRT_SCAN: begin
          cmp_vld_r <= issue;
          if (cmd.op == OP_SRT_SCAN && cmp_vld_r) begin
            head_r <= 1'b0;
          end
        end
        OP_SRT_RD: begin
          cmp_vld_r <= 1'b1;
          head_r    <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_ACCEPT: begin
        key_r        <= in_search_key;
        n_r          <= used_cnt;
        i_r          <= '0;
        lo_r         <= '0;
        hi1_r        <= used_cnt;
        s_r          <= '0;
        res_found_r  <= 1'b0;
        res_pos_r    <= '0;
        res_probes_r <= '0;
        res_kind_r   <= (in_action == ACT_SEARCH) ? KIND_SEARCH : KIND_SORT_DONE;
      end
      OP_LIN: begin
        cmp_idx_r <= i_r;
        if (issue) begin
          i_r <= i_r + CW'(1);
        end
        if (cmp_vld_r) begin
          res_found_r  <= key_eq;
          res_pos_r    <= key_eq ? POS_W'(cmp_idx_r) : '0;
          res_probes_r <= PRB_W'(cmp_idx_r + CW'(1));
        end
      end
      OP_SRT_SCAN: begin
        cmp_idx_r <= i_r;
        if (issue) begin
          i_r <= i_r + CW'(1);
        end
        if (cmp_vld_r) begin
          if (head_r) begin
            first_r <= rd_data_r;
            min_r   <= rd_data_r;
            best_r  <= cmp_idx_r;
          end else if (rd_lt_min) begin
            min_r  <= rd_data_r;
            best_r <= cmp_idx_r;
          end
        end
      end
      OP_SRT_RD: begin
        cmp_idx_r <= s_r;
        i_r       <= s_r + CW'(1);
      end
      OP_BIN_RD: mid_r <= mid;
      OP_BIN_CMP: begin
        res_probes_r <= res_probes_r + PRB_W'(1);
        if (key_eq) begin
          res_found_r <= 1'b1;
          res_pos_r   <= POS_W'(mid_r);
        end else if (rd_gt_key) begin
          hi1_r <= mid_r;
        end else begin
          lo_r <= mid_r + CW'(1);
        end
      end
      OP_SWAP_B: s_r <= s_r + CW'(1);
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_kind_r   <= res_kind_r;
      out_found_r  <= res_found_r;
      out_pos_r    <= res_pos_r;
      out_probes_r <= res_probes_r;
    end
  end

  assign status.cnt_zero   = used_cnt == '0;
  assign status.cnt_le1    = used_cnt <= CW'(1);
  assign status.method_bin = search_method_r;
  assign status.lin_hit    = cmp_vld_r && key_eq;
  assign status.scan_last  = cmp_vld_r && (cmp_idx_r == n_last);
  assign status.bin_empty  = !(lo_r < hi1_r);
  assign status.bin_hit    = key_eq;
  assign status.srt_more   = ({1'b0, s_r} + (CW+1)'(2)) < {1'b0, n_r};

  assign out_result_kind = out_kind_r;
  assign out_found       = out_found_r;
  assign out_position    = out_pos_r;
  assign out_probe_count = out_probes_r;

endmodule

FILE: src/sts_ctrl.sv
// Controller: sequences write, linear search, binary search and selection sort.
module sts_ctrl (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  input  logic [sts_pkg::ACT_W-1:0] in_action,
  input  logic                      out_ready,
  input  sts_pkg::dp_status_t       status,
  output sts_pkg::dp_cmd_t          cmd,
  output logic                      in_ready,
  output logic                      out_valid
);
  import sts_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   slot_free;

  assign slot_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          unique case (in_action)
            ACT_SORT:   state_nxt = status.cnt_le1 ? ST_EMIT : ST_SRT_RD;
            ACT_SEARCH: begin
              if (status.cnt_zero) begin
                state_nxt = ST_EMIT;
              end else begin
                state_nxt = status.method_bin ? ST_BIN_RD : ST_LIN;
              end
            end
            default: state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_LIN: begin
        if (status.lin_hit || status.scan_last) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_BIN_RD:   state_nxt = status.bin_empty ? ST_EMIT : ST_BIN_CMP;
      ST_BIN_CMP:  state_nxt = status.bin_hit ? ST_EMIT : ST_BIN_RD;
      ST_SRT_RD:   state_nxt = ST_SRT_SCAN;
      ST_SRT_SCAN: begin
        if (status.scan_last) begin
          state_nxt = ST_SWAP_A;
        end
      end
      ST_SWAP_A:   state_nxt = ST_SWAP_B;
      ST_SWAP_B:   state_nxt = status.srt_more ? ST_SRT_RD : ST_EMIT;
      ST_EMIT: begin
        if (slot_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd.op       = OP_IDLE;
    cmd.load_out = 1'b0;
    in_ready     = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op = OP_ACCEPT;
        end
      end
      ST_LIN:      cmd.op = OP_LIN;
      ST_BIN_RD:   cmd.op = OP_BIN_RD;
      ST_BIN_CMP:  cmd.op = OP_BIN_CMP;
      ST_SRT_RD:   cmd.op = OP_SRT_RD;
      ST_SRT_SCAN: cmd.op = OP_SRT_SCAN;
      ST_SWAP_A:   cmd.op = OP_SWAP_A;
      ST_SWAP_B:   cmd.op = OP_SWAP_B;
      ST_EMIT:     cmd.load_out = slot_free;
      default: ;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r && !out_ready;
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule
